// File: hw/rtl/matrix_chain_order_cost_top_defines.svh
// assertion macros for the matrix chain cost block
// used by matrix_chain_order_cost_top; expects clk and rst_n in scope
`ifndef MATRIX_CHAIN_ORDER_COST_TOP_DEFINES_SVH
`define MATRIX_CHAIN_ORDER_COST_TOP_DEFINES_SVH
`ifndef SYNTH
`define MCOC_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: implication check failed");
`define MCOC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");
`else
`define MCOC_ASSERT_IMPL(label, ante, cons)
`define MCOC_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// File: hw/rtl/mcoc_pkg.sv
// shared types and constants for the matrix chain cost block
// no dependencies
package mcoc_pkg;

  localparam int DIM_W    = 12;
  localparam int COST_W   = 48;
  localparam int STATUS_W = 2;

  localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_TOO_FEW  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_TOO_MANY = 2'd2;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SETUP,
    ST_CAPTURE,
    ST_RUN,
    ST_DRAIN
  } state_t;

endpackage

// File: hw/rtl/mcoc_ram.sv
// generic synchronous ram: one write port, two registered read ports
// no dependencies
module mcoc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// File: hw/rtl/matrix_chain_order_cost_top.sv
// matrix chain ordering cost: top level with sequencer and cost datapath
// depends on mcoc_pkg, mcoc_ram and matrix_chain_order_cost_top_defines.svh
//
// Usage: each input request carries one matrix dimension; the request with
// in_last_dimension set closes the chain. Non-final requests are stored and
// give no result. The final request gives exactly one result request with
// the least multiplication count and a status (ok, too few, too many).
// Error cases and a two-dimension chain answer in the cycle after the final
// request. Otherwise the interval cost table is filled bottom-up: per
// interval (i,j) a set-up, then the j-i split points at one per cycle,
// then a drain; that rate is set by the single two-port cost table ram and
// the four-stage split pipeline. in_ready is low while the table is being
// filled. A new chain may be loaded while a result waits; only its final
// request waits for the result register to empty. out_valid holds with a
// stable payload until out_ready. Reset clears the count, the overflow
// flag and the sequencer; both rams need no clearing since every entry is
// written before use.
`include "matrix_chain_order_cost_top_defines.svh"
module matrix_chain_order_cost_top #(
  parameter int MAX_DIMS = 64
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [mcoc_pkg::DIM_W-1:0]       in_dimension,
  input  logic                             in_last_dimension,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [mcoc_pkg::COST_W-1:0]      out_min_cost,
  output logic [mcoc_pkg::STATUS_W-1:0]    out_status
);

  localparam int IW        = $clog2(MAX_DIMS);
  localparam int CW        = $clog2(MAX_DIMS + 1);
  localparam int CostDepth = 1 << (2 * IW);
  localparam int DW        = mcoc_pkg::DIM_W;
  localparam int CSTW      = mcoc_pkg::COST_W;
  localparam int SUMW      = CSTW + 1;
  localparam int CANDW     = CSTW + 2;
  localparam int P1W       = 2 * DW;
  localparam int P2W       = 3 * DW;

  mcoc_pkg::state_t state_r, state_nxt;

  logic [CW-1:0] count_r, count_nxt;
  logic          overflow_r, overflow_nxt;
  logic [CW-1:0] n_r, n_nxt;
  logic [IW-1:0] i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;
  logic [DW-1:0] di_r, di_nxt, dj_r, dj_nxt;

  logic v1_r, v2_r, v3_r, issue;
  logic zl1_r, zr1_r;
  logic [SUMW-1:0]  sum1_r, sum1_nxt, sum2_r;
  logic [P1W-1:0]   p1_r, p1_nxt;
  logic [P2W-1:0]   p2_r;
  logic [CANDW-1:0] cand, best_r, best_nxt;
  logic             have_r, have_nxt;

  logic                              out_valid_r, out_valid_nxt;
  logic [CSTW-1:0]                   out_cost_r, out_cost_nxt;
  logic [mcoc_pkg::STATUS_W-1:0]     out_status_r, out_status_nxt;

  logic            dim_we;
  logic [IW-1:0]   dim_ra_a, dim_ra_b;
  logic [DW-1:0]   dim_rd_a, dim_rd_b;
  logic            cost_we;
  logic [2*IW-1:0] cost_wa;
  logic [CSTW-1:0] cost_rd_a, cost_rd_b;
  logic [CSTW-1:0] left_cost, right_cost;

  logic          in_fire;
  logic [CW-1:0] cnt_after;
  logic          ovf_after;

  mcoc_ram #(.WIDTH(DW), .DEPTH(MAX_DIMS)) u_dim_ram (
    .clk     (clk),
    .we      (dim_we),
    .waddr   (count_r[IW-1:0]),
    .wdata   (in_dimension),
    .raddr_a (dim_ra_a),
    .raddr_b (dim_ra_b),
    .rdata_a (dim_rd_a),
    .rdata_b (dim_rd_b)
  );

  mcoc_ram #(.WIDTH(CSTW), .DEPTH(CostDepth)) u_cost_ram (
    .clk     (clk),
    .we      (cost_we),
    .waddr   (cost_wa),
    .wdata   (best_r[CSTW-1:0]),
    .raddr_a ({i_r, k_r}),
    .raddr_b ({k_r + IW'(1), j_r}),
    .rdata_a (cost_rd_a),
    .rdata_b (cost_rd_b)
  );

  assign in_ready = (state_r == mcoc_pkg::ST_LOAD) && (!in_last_dimension || !out_valid_r);
  assign in_fire  = in_valid && in_ready;

  assign out_valid    = out_valid_r;
  assign out_min_cost = out_cost_r;
  assign out_status   = out_status_r;

  // split pipeline: table reads, sum and first product, second product, compare
  assign left_cost  = zl1_r ? '0 : cost_rd_a;
  assign right_cost = zr1_r ? '0 : cost_rd_b;
  assign sum1_nxt   = SUMW'(left_cost) + SUMW'(right_cost);
  assign p1_nxt     = P1W'(di_r) * P1W'(dim_rd_a);
  assign cand       = CANDW'(sum2_r) + CANDW'(p2_r);

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    overflow_nxt   = overflow_r;
    n_nxt          = n_r;
    i_nxt          = i_r;
    j_nxt          = j_r;
    k_nxt          = k_r;
    di_nxt         = di_r;
    dj_nxt         = dj_r;
    have_nxt       = have_r;
    best_nxt       = best_r;
    out_valid_nxt  = out_valid_r;
    out_cost_nxt   = out_cost_r;
    out_status_nxt = out_status_r;
    dim_we         = 1'b0;
    dim_ra_a       = k_r;
    dim_ra_b       = j_r;
    cost_we        = 1'b0;
    cost_wa        = {i_r, j_r};
    issue          = 1'b0;
    cnt_after      = count_r;
    ovf_after      = overflow_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    if (v3_r && (!have_r || cand < best_r)) begin
      best_nxt = cand;
      have_nxt = 1'b1;
    end

    case (state_r)
      mcoc_pkg::ST_LOAD: begin
        if (in_fire) begin
          if (count_r < CW'(MAX_DIMS)) begin
            dim_we    = 1'b1;
            cnt_after = count_r + CW'(1);
          end else begin
            ovf_after = 1'b1;
          end
          count_nxt    = cnt_after;
          overflow_nxt = ovf_after;
          if (in_last_dimension) begin
            count_nxt    = '0;
            overflow_nxt = 1'b0;
            out_cost_nxt = '0;
            if (ovf_after) begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = mcoc_pkg::STATUS_TOO_MANY;
            end else if (cnt_after < CW'(2)) begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = mcoc_pkg::STATUS_TOO_FEW;
            end else if (cnt_after == CW'(2)) begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = mcoc_pkg::STATUS_OK;
            end else begin
              n_nxt     = cnt_after;
              i_nxt     = IW'(1);
              j_nxt     = IW'(2);
              state_nxt = mcoc_pkg::ST_SETUP;
            end
          end
        end
      end
      mcoc_pkg::ST_SETUP: begin
        dim_ra_a  = i_r - IW'(1);
        dim_ra_b  = j_r;
        k_nxt     = i_r;
        have_nxt  = 1'b0;
        state_nxt = mcoc_pkg::ST_CAPTURE;
      end
      mcoc_pkg::ST_CAPTURE: begin
        di_nxt    = dim_rd_a;
        dj_nxt    = dim_rd_b;
        state_nxt = mcoc_pkg::ST_RUN;
      end
      mcoc_pkg::ST_RUN: begin
        issue = 1'b1;
        if (k_r == j_r - IW'(1)) begin
          state_nxt = mcoc_pkg::ST_DRAIN;
        end else begin
          k_nxt = k_r + IW'(1);
        end
      end
      mcoc_pkg::ST_DRAIN: begin
        // write back only once the last split has been compared
        if (!v1_r && !v2_r && !v3_r) begin
          cost_we = 1'b1;
          if (CW'(j_r) == n_r - CW'(1)) begin
            if (i_r == IW'(1)) begin
              out_valid_nxt  = 1'b1;
              out_cost_nxt   = best_r[CSTW-1:0];
              out_status_nxt = mcoc_pkg::STATUS_OK;
              state_nxt      = mcoc_pkg::ST_LOAD;
            end else begin
              // next chain length, starting again at the left end
              i_nxt     = IW'(1);
              j_nxt     = j_r - i_r + IW'(2);
              state_nxt = mcoc_pkg::ST_SETUP;
            end
          end else begin
            i_nxt     = i_r + IW'(1);
            j_nxt     = j_r + IW'(1);
            state_nxt = mcoc_pkg::ST_SETUP;
          end
        end
      end
      default: begin
        state_nxt = mcoc_pkg::ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mcoc_pkg::ST_LOAD;
      count_r     <= '0;
      overflow_r  <= 1'b0;
      out_valid_r <= 1'b0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      have_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      overflow_r  <= overflow_nxt;
      out_valid_r <= out_valid_nxt;
      v1_r        <= issue;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      have_r      <= have_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r          <= n_nxt;
    i_r          <= i_nxt;
    j_r          <= j_nxt;
    k_r          <= k_nxt;
    di_r         <= di_nxt;
    dj_r         <= dj_nxt;
    best_r       <= best_nxt;
    out_cost_r   <= out_cost_nxt;
    out_status_r <= out_status_nxt;
    // single-matrix intervals cost nothing and are never stored
    zl1_r        <= (k_r == i_r);
    zr1_r        <= (k_r + IW'(1) == j_r);
    sum1_r       <= sum1_nxt;
    p1_r         <= p1_nxt;
    sum2_r       <= sum1_r;
    p2_r         <= P2W'(p1_r) * P2W'(dj_r);
  end

  `MCOC_ASSERT_IMPL(a_pipe_empty_at_setup, state_r == mcoc_pkg::ST_SETUP, !v1_r && !v2_r && !v3_r)
  `MCOC_ASSERT_IMPL(a_split_in_range, state_r == mcoc_pkg::ST_RUN, (k_r >= i_r) && (k_r < j_r))
  `MCOC_ASSERT_IMPL(a_no_result_while_filling, state_r != mcoc_pkg::ST_LOAD, !out_valid_r)
  `MCOC_ASSERT_NEXT(a_chain_cleared, in_fire && in_last_dimension, (count_r == '0) && !overflow_r)
  `MCOC_ASSERT_IMPL(a_error_cost_zero, out_valid_r && (out_status_r != mcoc_pkg::STATUS_OK), out_cost_r == '0)

endmodule

// File: tb/tb.sv
// self-checking testbench for matrix_chain_order_cost_top: random dimension chains in,
// least multiplication counts checked against an in-bench dynamic-programming predictor
// depends on mcoc_pkg and the matrix_chain_order_cost_top rtl
`timescale 1ns / 100ps
module tb;

  localparam int DIM_W    = mcoc_pkg::DIM_W;
  localparam int COST_W   = mcoc_pkg::COST_W;
  localparam int STATUS_W = mcoc_pkg::STATUS_W;

  localparam int MAX_DIMS      = 64;
  localparam int RANDOM_ITEMS  = 850;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int SETTLE_CYCLES = 100;
  localparam int MAX_REPORTS   = 10;

  // directed chains, laid end to end; each chain's final dimension closes it
  localparam int DIRECTED_LENS [6] = '{1, 2, 4, 4, 4, 5};
  localparam int DIRECTED_DIMS [20] = '{
    4095,
    4095, 4095,
    4095, 4095, 4095, 4095,
    1, 4095, 1, 4095,
    10, 0, 30, 40,
    40, 20, 30, 10, 30
  };

  typedef struct {
    logic [DIM_W-1:0] dim;
    logic             closes;
  } dim_request_t;

  typedef struct {
    logic [COST_W-1:0]   cost;
    logic [STATUS_W-1:0] status;
  } chain_result_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [DIM_W-1:0]    in_dimension = '0;
  logic                in_last_dimension = 1'b0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [COST_W-1:0]   out_min_cost;
  logic [STATUS_W-1:0] out_status;

  dim_request_t  pending_dims [$];
  chain_result_t expected_results [$];

  // predictor state
  logic [DIM_W-1:0] held_dims [0:MAX_DIMS-1];
  logic [63:0]      span_cost [0:MAX_DIMS-1][0:MAX_DIMS-1];
  int               held_count = 0;
  bit               store_overflowed = 1'b0;

  int  mismatches = 0;
  int  results_seen = 0;
  int  cycle_count = 0;
  int  send_wait = 0;
  bit  send_burst = 1'b0;
  int  recv_wait = 0;
  bit  recv_burst = 1'b0;
  int  hold;
  dim_request_t  next_req;
  chain_result_t want;

  matrix_chain_order_cost_top #(
    .MAX_DIMS(MAX_DIMS)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_dimension(in_dimension),
    .in_last_dimension(in_last_dimension),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_min_cost(out_min_cost),
    .out_status(out_status)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // bottom-up interval table over the stored dimensions, exact at 64 bits
  function automatic logic [63:0] least_product_count(input int n);
    logic [63:0] best;
    logic [63:0] c;
    int j;
    for (int i = 1; i < n; i++) span_cost[i][i] = '0;
    for (int span = 2; span < n; span++) begin
      for (int i = 1; i + span - 1 < n; i++) begin
        j = i + span - 1;
        best = '0;
        for (int k = i; k < j; k++) begin
          c = span_cost[i][k] + span_cost[k+1][j]
            + 64'(held_dims[i-1]) * 64'(held_dims[k]) * 64'(held_dims[j]);
          if (k == i || c < best) best = c;
        end
        span_cost[i][j] = best;
      end
    end
    return span_cost[1][n-1];
  endfunction

  function automatic void take_dimension(input logic [DIM_W-1:0] dim, input logic closes);
    chain_result_t res;
    if (held_count < MAX_DIMS) begin
      held_dims[held_count] = dim;
      held_count++;
    end else begin
      store_overflowed = 1'b1;
    end
    if (closes) begin
      res.cost = '0;
      if (store_overflowed) begin
        res.status = mcoc_pkg::STATUS_TOO_MANY;
      end else if (held_count < 2) begin
        res.status = mcoc_pkg::STATUS_TOO_FEW;
      end else begin
        res.status = mcoc_pkg::STATUS_OK;
        res.cost = COST_W'(least_product_count(held_count));
      end
      expected_results.push_back(res);
      held_count = 0;
      store_overflowed = 1'b0;
    end
  endfunction

  function automatic logic [DIM_W-1:0] draw_dimension();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r == 1) return '1;
    if (r == 2) return DIM_W'(1);
    return DIM_W'($urandom_range(1, 4095));
  endfunction

  function automatic void queue_chain(input int len);
    dim_request_t req;
    for (int m = 0; m < len; m++) begin
      req.dim = draw_dimension();
      req.closes = (m == len - 1);
      pending_dims.push_back(req);
    end
  endfunction

  // driver: one request in flight, payload held until accepted
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_wait <= 0;
    end else begin
      if (in_valid && in_ready) take_dimension(in_dimension, in_last_dimension);
      if (!in_valid || in_ready) begin
        if (send_wait > 0 || pending_dims.size() == 0) begin
          in_valid <= 1'b0;
          if (send_wait > 0) send_wait <= send_wait - 1;
        end else begin
          next_req = pending_dims.pop_front();
          in_valid <= 1'b1;
          in_dimension <= next_req.dim;
          in_last_dimension <= next_req.closes;
          // occasional switch between back-to-back and gappy stretches
          if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
          send_wait <= send_burst ? 0 : $urandom_range(0, 9);
        end
      end
    end
  end

  // monitor: stalls counted only while a result is offered
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      recv_wait <= $urandom_range(0, 9);
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("result %0d unexpected: cost %0d status %0d",
                     results_seen, out_min_cost, out_status);
        end else begin
          want = expected_results.pop_front();
          if (out_min_cost !== want.cost || out_status !== want.status) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("result %0d: expected cost %0d status %0d, got cost %0d status %0d",
                       results_seen, want.cost, want.status, out_min_cost, out_status);
          end
        end
        if ($urandom_range(0, 9) == 0) recv_burst = !recv_burst;
        hold = recv_burst ? 0 : $urandom_range(0, 9);
        recv_wait <= hold;
        out_ready <= (hold == 0);
      end else if (out_valid && recv_wait > 0) begin
        recv_wait <= recv_wait - 1;
        out_ready <= (recv_wait == 1);
      end else begin
        out_ready <= (recv_wait == 0);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    int pos;
    int chain_no;
    int queued;
    int len;
    int r;
    dim_request_t req;

    pos = 0;
    foreach (DIRECTED_LENS[c]) begin
      for (int m = 0; m < DIRECTED_LENS[c]; m++) begin
        req.dim = DIM_W'(DIRECTED_DIMS[pos]);
        req.closes = (m == DIRECTED_LENS[c] - 1);
        pending_dims.push_back(req);
        pos++;
      end
    end

    // mostly short chains; a few full stores, overflowing stores and single dimensions
    chain_no = 0;
    queued = 0;
    while (queued < RANDOM_ITEMS) begin
      r = $urandom_range(0, 99);
      if (chain_no == 8 || chain_no == 70) len = MAX_DIMS;
      else if (chain_no == 30) len = MAX_DIMS + 1;
      else if (chain_no == 50) len = $urandom_range(MAX_DIMS + 2, MAX_DIMS + 12);
      else if (r < 6) len = 1;
      else if (r < 10) len = $urandom_range(13, 32);
      else len = $urandom_range(2, 12);
      queue_chain(len);
      queued += len;
      chain_no++;
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    do @(negedge clk); while (pending_dims.size() != 0 || in_valid);
    while (expected_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
